/* rtl/macb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// macb_pkg
// Types and constants shared by the MacBinary stream demux.
// ----------------------------------------------------------------------------
package macb_pkg;

	localparam int unsigned HDR_BYTES   = 128;
	localparam int unsigned NAME_MAX    = 31;
	localparam int unsigned DATA_LEN_AT = 83;
	localparam int unsigned RSRC_LEN_AT = 87;
	localparam int unsigned BLOCK_ROUND = 127;
	localparam logic [31:0] TOTAL_RESET = 32'd850000;

	localparam logic [2:0] ROUTE_HEADER   = 3'd0;
	localparam logic [2:0] ROUTE_DATA     = 3'd1;
	localparam logic [2:0] ROUTE_PAD      = 3'd2;
	localparam logic [2:0] ROUTE_RSRC     = 3'd3;
	localparam logic [2:0] ROUTE_TRAILING = 3'd4;
	localparam logic [2:0] ROUTE_DROPPED  = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  route;
		logic [7:0]  out_byte;
		logic [31:0] fork_offset;
		logic        header_done;
		logic        header_error;
		logic [30:0] data_length;
		logic [30:0] rsrc_length;
		logic [7:0]  name_length;
	} out_item_t;

endpackage
`default_nettype wire

/* rtl/macbinary_stream_demux.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// macbinary_stream_demux
// Parses a MacBinary byte stream: header capture and check, fork routing.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | sink      | in_valid / in_stall  | in_data (data_byte, start_req)
// out     | source    | out_valid / out_stall| out_data (route, offsets, lengths)
// cfg     | sink      | cfg_we               | cfg_wdata (max_total_length)
//
// one byte per cycle unless in_stall; result is on out next cycle unless out stalls
// the byte is parsed in a single pass of logic feeding a result register
// a skid stage behind the result register lets input run while output stalls
// in_stall rises only when both result and skid stages hold data
// asynchronous reset clears transfer state and sets max_total_length to 850000
// ----------------------------------------------------------------------------
module macbinary_stream_demux (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire  [31:0]          cfg_wdata,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  macb_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output macb_pkg::out_item_t  out_data
);

	logic                accept;
	logic                buf_full;
	macb_pkg::out_item_t result;

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	macb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (in_data),
		.result    (result)
	);

	macb_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (buf_full),
		.valid     (out_valid),
		.stall     (out_stall),
		.data      (out_data)
	);

endmodule
`default_nettype wire

/* rtl/macb_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// macb_core
// Transfer state, header capture and validation, byte routing for one byte.
// ----------------------------------------------------------------------------
module macb_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [31:0]         cfg_wdata,
	input  wire                 accept,
	input  macb_pkg::in_item_t  item,
	output macb_pkg::out_item_t result
);

	logic [31:0] max_total_q;
	logic [31:0] pos_q;
	logic        lead_bad_q;
	logic [7:0]  name_len_q;
	logic [31:0] data_len_q;
	logic [31:0] rsrc_len_q;
	logic        failed_q;

	// boundaries precomputed near the end of the header
	logic [31:0] dend_q;   // data length + header
	logic [31:0] pad_q;    // padded data length + header
	logic [32:0] end_q;    // pad_q + resource length

	logic [31:0] eff_pos;
	logic        eff_lead;
	logic [7:0]  eff_name;
	logic [31:0] eff_dlen;
	logic [31:0] eff_rlen;
	logic        eff_failed;

	logic        in_hdr;
	logic [6:0]  hpos;
	logic        nxt_lead;
	logic [7:0]  nxt_name;
	logic [31:0] nxt_dlen;
	logic [31:0] nxt_rlen;
	logic        hdr_ok;
	logic        last_hdr;
	logic [32:0] len_sum;
	logic [31:0] off_hdr;
	logic [31:0] off_rsrc;
	logic [2:0]  route;
	logic [31:0] offset;

	// a start clears the transfer before this byte is looked at
	always_comb begin
		if (item.start_req) begin
			eff_pos    = '0;
			eff_lead   = 1'b0;
			eff_name   = '0;
			eff_dlen   = '0;
			eff_rlen   = '0;
			eff_failed = 1'b0;
		end else begin
			eff_pos    = pos_q;
			eff_lead   = lead_bad_q;
			eff_name   = name_len_q;
			eff_dlen   = data_len_q;
			eff_rlen   = rsrc_len_q;
			eff_failed = failed_q;
		end
	end

	assign in_hdr   = (eff_pos[31:7] == '0);
	assign hpos     = eff_pos[6:0];
	assign last_hdr = in_hdr && (hpos == 7'(macb_pkg::HDR_BYTES - 1));
	assign len_sum  = {1'b0, eff_dlen} + {1'b0, eff_rlen};

	always_comb begin
		hdr_ok = !eff_lead
			&& (eff_name >= 8'd1) && (eff_name <= 8'(macb_pkg::NAME_MAX))
			&& !eff_dlen[31] && !eff_rlen[31]
			&& (len_sum <= {1'b0, max_total_q});
	end

	always_comb begin
		nxt_lead = eff_lead;
		nxt_name = eff_name;
		nxt_dlen = eff_dlen;
		nxt_rlen = eff_rlen;
		if (!eff_failed && in_hdr) begin
			if (hpos == 7'd0) begin
				nxt_lead = (item.data_byte != 8'd0);
			end else if (hpos == 7'd1) begin
				nxt_name = item.data_byte;
			end else if (hpos >= 7'(macb_pkg::DATA_LEN_AT)
					&& hpos < 7'(macb_pkg::DATA_LEN_AT + 4)) begin
				nxt_dlen = {eff_dlen[23:0], item.data_byte};
			end else if (hpos >= 7'(macb_pkg::RSRC_LEN_AT)
					&& hpos < 7'(macb_pkg::RSRC_LEN_AT + 4)) begin
				nxt_rlen = {eff_rlen[23:0], item.data_byte};
			end
		end
	end

	assign off_hdr  = eff_pos - 32'(macb_pkg::HDR_BYTES);
	assign off_rsrc = eff_pos - pad_q;

	always_comb begin
		route  = macb_pkg::ROUTE_DROPPED;
		offset = '0;
		if (!eff_failed) begin
			if (in_hdr) begin
				route  = macb_pkg::ROUTE_HEADER;
				offset = eff_pos;
			end else if (eff_pos < dend_q) begin
				route  = macb_pkg::ROUTE_DATA;
				offset = off_hdr;
			end else if (eff_pos < pad_q) begin
				route  = macb_pkg::ROUTE_PAD;
				offset = off_hdr;
			end else begin
				offset = off_rsrc;
				route  = ({1'b0, eff_pos} < end_q) ? macb_pkg::ROUTE_RSRC
					: macb_pkg::ROUTE_TRAILING;
			end
		end
	end

	always_comb begin
		result.route        = route;
		result.out_byte     = item.data_byte;
		result.fork_offset  = offset;
		result.header_done  = !eff_failed && last_hdr && hdr_ok;
		result.header_error = !eff_failed && last_hdr && !hdr_ok;
		result.data_length  = nxt_dlen[30:0];
		result.rsrc_length  = nxt_rlen[30:0];
		result.name_length  = nxt_name;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q <= macb_pkg::TOTAL_RESET;
		end else if (cfg_we) begin
			max_total_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			lead_bad_q <= 1'b0;
			name_len_q <= '0;
			data_len_q <= '0;
			rsrc_len_q <= '0;
			failed_q   <= 1'b0;
		end else if (accept) begin
			lead_bad_q <= nxt_lead;
			name_len_q <= nxt_name;
			data_len_q <= nxt_dlen;
			rsrc_len_q <= nxt_rlen;
			failed_q   <= eff_failed || (last_hdr && !hdr_ok);
			if (!eff_failed && eff_pos != '1) begin
				pos_q <= eff_pos + 32'd1;
			end else begin
				pos_q <= eff_pos;
			end
		end
	end

	// lengths are final after byte 90, so the boundaries settle on bytes 126 and 127
	always_ff @(posedge clk) begin
		if (accept && !eff_failed && in_hdr) begin
			if (hpos == 7'(macb_pkg::HDR_BYTES - 2)) begin
				dend_q <= eff_dlen + 32'(macb_pkg::HDR_BYTES);
				pad_q  <= (eff_dlen + 32'(macb_pkg::BLOCK_ROUND + macb_pkg::HDR_BYTES))
					& ~32'(macb_pkg::BLOCK_ROUND);
			end
			if (last_hdr) begin
				end_q <= {1'b0, pad_q} + {1'b0, eff_rlen};
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/macb_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// macb_out_buf
// Result register with a skid stage; input stall comes from a register.
// ----------------------------------------------------------------------------
module macb_out_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  macb_pkg::out_item_t  push_data,
	output logic                 full,
	output logic                 valid,
	input  wire                  stall,
	output macb_pkg::out_item_t  data
);

	logic                out_valid_q;
	logic                skid_valid_q;
	macb_pkg::out_item_t out_q;
	macb_pkg::out_item_t skid_q;
	logic                out_free;

	assign out_free = !out_valid_q || !stall;
	assign full     = skid_valid_q;
	assign valid    = out_valid_q;
	assign data     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

/* sim/macbinary_stream_demux_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macbinary_stream_demux_tb
// Drives MacBinary transfers into the demux and compares every tagged byte
// against a cycle-free software parser kept in step with accepted input.
// Directed cases cover fork routing, restarts, header checks and a full-width
// length limit; random transfers follow with idling and output stalls.
// ----------------------------------------------------------------------------
module macbinary_stream_demux_tb;

	localparam int unsigned STUCK_LIMIT = 2000;
	localparam int unsigned SHOWN_MAX   = 10;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [31:0]         cfg_wdata = '0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	macb_pkg::in_item_t  in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	macb_pkg::out_item_t out_data;

	// parser state mirrored from accepted transfers
	logic [31:0] stream_pos  = '0;
	logic        lead_bad    = 1'b0;
	logic [7:0]  name_len_q  = '0;
	logic [31:0] data_len_q  = '0;
	logic [31:0] rsrc_len_q  = '0;
	logic        hdr_failed  = 1'b0;
	logic [31:0] total_limit = macb_pkg::TOTAL_RESET;

	macb_pkg::out_item_t pending_routes [$];
	int unsigned mismatches  = 0;
	int unsigned idle_cycles = 0;
	int unsigned bytes_sent  = 0;
	bit          calm        = 1'b0;

	macbinary_stream_demux u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void restart_transfer();
		stream_pos = '0;
		lead_bad   = 1'b0;
		name_len_q = '0;
		data_len_q = '0;
		rsrc_len_q = '0;
		hdr_failed = 1'b0;
	endfunction

	function automatic macb_pkg::out_item_t route_byte(input macb_pkg::in_item_t it);
		macb_pkg::out_item_t r;
		logic [31:0] off;
		logic [31:0] padded;
		logic [32:0] total;
		r = '0;
		r.route    = macb_pkg::ROUTE_DROPPED;
		r.out_byte = it.data_byte;
		if (it.start_req)
			restart_transfer();
		if (!hdr_failed) begin
			if (stream_pos < macb_pkg::HDR_BYTES) begin
				r.route       = macb_pkg::ROUTE_HEADER;
				r.fork_offset = stream_pos;
				if (stream_pos == 0)
					lead_bad = (it.data_byte != 8'd0);
				else if (stream_pos == 1)
					name_len_q = it.data_byte;
				else if (stream_pos >= macb_pkg::DATA_LEN_AT
					&& stream_pos < macb_pkg::DATA_LEN_AT + 4)
					data_len_q = {data_len_q[23:0], it.data_byte};
				else if (stream_pos >= macb_pkg::RSRC_LEN_AT
					&& stream_pos < macb_pkg::RSRC_LEN_AT + 4)
					rsrc_len_q = {rsrc_len_q[23:0], it.data_byte};
				if (stream_pos == macb_pkg::HDR_BYTES - 1) begin
					// sum taken one bit wider so it cannot wrap
					total = {1'b0, data_len_q} + {1'b0, rsrc_len_q};
					if (!lead_bad && name_len_q >= 8'd1 && name_len_q <= macb_pkg::NAME_MAX &&
					    !data_len_q[31] && !rsrc_len_q[31] && total <= {1'b0, total_limit}) begin
						r.header_done = 1'b1;
					end else begin
						r.header_error = 1'b1;
						hdr_failed     = 1'b1;
					end
				end
			end else begin
				off    = stream_pos - macb_pkg::HDR_BYTES;
				padded = (data_len_q + 32'(macb_pkg::BLOCK_ROUND))
					& ~32'(macb_pkg::BLOCK_ROUND);
				if (off < data_len_q) begin
					r.route       = macb_pkg::ROUTE_DATA;
					r.fork_offset = off;
				end else if (off < padded) begin
					r.route       = macb_pkg::ROUTE_PAD;
					r.fork_offset = off;
				end else begin
					r.fork_offset = off - padded;
					r.route       = (r.fork_offset < rsrc_len_q) ? macb_pkg::ROUTE_RSRC
						: macb_pkg::ROUTE_TRAILING;
				end
			end
			if (!hdr_failed && stream_pos != 32'hFFFF_FFFF)
				stream_pos = stream_pos + 1;
			if (hdr_failed && r.header_error)
				stream_pos = stream_pos + 1;
		end
		r.data_length = data_len_q[30:0];
		r.rsrc_length = rsrc_len_q[30:0];
		r.name_length = name_len_q;
		return r;
	endfunction

	task automatic cmp_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < SHOWN_MAX)
				$display("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input macb_pkg::out_item_t want, input macb_pkg::out_item_t got);
		cmp_field("route", want.route, got.route);
		cmp_field("out_byte", want.out_byte, got.out_byte);
		cmp_field("fork_offset", want.fork_offset, got.fork_offset);
		cmp_field("header_done", want.header_done, got.header_done);
		cmp_field("header_error", want.header_error, got.header_error);
		cmp_field("data_length", want.data_length, got.data_length);
		cmp_field("rsrc_length", want.rsrc_length, got.rsrc_length);
		cmp_field("name_length", want.name_length, got.name_length);
	endtask

	// result check, prediction of accepted bytes and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_routes.size() == 0) begin
					if (mismatches < SHOWN_MAX)
						$display("unexpected result: %h", out_data);
					mismatches++;
				end else begin
					check_result(pending_routes.pop_front(), out_data);
				end
			end
			if (in_valid && !in_stall)
				pending_routes.push_back(route_byte(in_data));
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STUCK_LIMIT) begin
				$display("macbinary_stream_demux: mismatch");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 21);
	end

	task automatic send_byte(input logic [7:0] b, input logic s);
		macb_pkg::in_item_t it;
		it.data_byte = b;
		it.start_req = s;
		while (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// header with the given fields and random filler, cut short if asked,
	// then body bytes without a start
	task automatic send_transfer(input bit with_start, input logic [7:0] lead,
	                             input logic [7:0] nlen, input logic [31:0] dlen,
	                             input logic [31:0] rlen, input int unsigned hdr_cut,
	                             input int unsigned body_len);
		logic [7:0] hdr [macb_pkg::HDR_BYTES];
		for (int i = 0; i < macb_pkg::HDR_BYTES; i++)
			hdr[i] = 8'($urandom);
		hdr[0] = lead;
		hdr[1] = nlen;
		for (int i = 0; i < 4; i++) begin
			hdr[macb_pkg::DATA_LEN_AT + i] = dlen[31 - 8 * i -: 8];
			hdr[macb_pkg::RSRC_LEN_AT + i] = rlen[31 - 8 * i -: 8];
		end
		for (int i = 0; i < hdr_cut && i < macb_pkg::HDR_BYTES; i++)
			send_byte(hdr[i], with_start && i == 0);
		for (int i = 0; i < body_len; i++)
			send_byte(8'($urandom), 1'b0);
	endtask

	// sender holds off until every predicted result is out
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_routes.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_total_limit(input logic [31:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		total_limit = v;
	endtask

	task automatic test_no_start();
		// parsed as if a transfer began at reset; body runs through the data, pad, resource and trailing routes
		send_transfer(1'b0, 8'h00, 8'd5, 32'd5, 32'd3, macb_pkg::HDR_BYTES, 134);
	endtask

	task automatic test_restart();
		send_transfer(1'b1, 8'h00, 8'd9, 32'd4, 32'd4, 85, 0);
		send_transfer(1'b1, 8'h00, 8'd9, 32'd4, 32'd4, 40, 0);
	endtask

	task automatic test_header_checks();
		send_transfer(1'b1, 8'h01, 8'd5, 32'd0, 32'd0, macb_pkg::HDR_BYTES, 2);
		send_transfer(1'b1, 8'h00, 8'd32, 32'd0, 32'd0, macb_pkg::HDR_BYTES, 0);
		// sum one over the limit
		send_transfer(1'b1, 8'h00, 8'd7, 32'd849000, 32'd1001, macb_pkg::HDR_BYTES, 1);
	endtask

	task automatic test_limit_extremes();
		// sum needs the full 32 bits and sits right at the limit
		set_total_limit(32'hFFFF_FFFE);
		send_transfer(1'b1, 8'h00, 8'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			macb_pkg::HDR_BYTES, 3);
	endtask

	task automatic test_random_transfers();
		logic [31:0] limits [2];
		logic [31:0] lim;
		logic [31:0] dlen;
		logic [31:0] rlen;
		logic [31:0] target;
		logic [7:0]  lead;
		logic [7:0]  nlen;
		int unsigned kind;
		int unsigned room;
		int unsigned body;
		int unsigned stop_at;
		limits = '{32'd0, macb_pkg::TOTAL_RESET};
		for (int phase = 0; phase < 2; phase++) begin
			set_total_limit(limits[phase]);
			lim     = limits[phase];
			calm    = (phase == 1);
			stop_at = bytes_sent + 100;
			while (bytes_sent < stop_at) begin
				kind = $urandom_range(9);
				room = (lim > 60) ? 60 : lim;
				lead = 8'h00;
				nlen = 8'($urandom_range(macb_pkg::NAME_MAX, 1));
				dlen = $urandom_range(room, 0);
				rlen = $urandom_range(room - dlen, 0);
				body = $urandom_range(((dlen + 127) / 128) * 128 + rlen + 10, 0);
				case (kind)
					6: begin
						case ($urandom_range(4))
							0: lead = 8'($urandom_range(255, 1));
							1: nlen = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 32));
							2: dlen = dlen | 32'h8000_0000;
							3: rlen = rlen | 32'h8000_0000;
							default: begin
								target = lim + 1;
								dlen   = target >> 1;
								rlen   = target - dlen;
							end
						endcase
						send_transfer(1'b1, lead, nlen, dlen, rlen, macb_pkg::HDR_BYTES,
							$urandom_range(6, 0));
					end
					7: send_transfer(1'b1, lead, nlen, dlen, rlen, $urandom_range(127, 1), 0);
					8: send_transfer(1'b0, 8'($urandom), 8'($urandom), $urandom, $urandom,
						$urandom_range(20, 1), 0);
					9: begin
						dlen = $urandom_range((lim > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : lim, 0);
						rlen = $urandom_range(((lim - dlen) > 32'h7FFF_FFFF) ?
							32'h7FFF_FFFF : (lim - dlen), 0);
						send_transfer(1'b1, lead, nlen, dlen, rlen, macb_pkg::HDR_BYTES, 12);
					end
					default: send_transfer(1'b1, lead, nlen, dlen, rlen,
						macb_pkg::HDR_BYTES, body);
				endcase
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_start();
		test_restart();
		test_header_checks();
		test_limit_extremes();
		test_random_transfers();
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("macbinary_stream_demux: match");
		else
			$display("macbinary_stream_demux: mismatch");
		$finish;
	end

endmodule
